### hw/rtl/windowed_moving_average_unit_macros.svh
// assertion helpers used by the checker file
`ifndef WINDOWED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define WINDOWED_MOVING_AVERAGE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WMA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WMA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/wma_pkg.sv
`default_nettype none

package wma_pkg;

    // default sizes
    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WIN_RESET_DEF   = 32;

    // fixed field widths
    localparam int CFG_W  = 6;
    localparam int AVG_W  = 24;
    localparam int FRAC_W = 8;

    // saturation limits of the average, as magnitudes and as signed values
    localparam logic [AVG_W:0] AVG_POS_LIM = (AVG_W + 1)'((1 << (AVG_W - 1)) - 1);
    localparam logic [AVG_W:0] AVG_NEG_LIM = (AVG_W + 1)'(1 << (AVG_W - 1));
    localparam logic [AVG_W-1:0] AVG_MAX   = {1'b0, {(AVG_W - 1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN   = {1'b1, {(AVG_W - 1){1'b0}}};

    // request kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // control sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/wma_in_if.sv
`default_nettype none

interface wma_in_if #(
    parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/wma_out_if.sv
`default_nettype none

interface wma_out_if #(
    parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW_DEF
);
    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);

    logic                       valid;
    logic                       ready;
    logic [wma_pkg::AVG_W-1:0]  average_q8;
    logic [COUNT_W-1:0]         held_count;

    modport source (output valid, output average_q8, output held_count, input ready);
    modport sink   (input valid, input average_q8, input held_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/wma_cfg_if.sv
`default_nettype none

interface wma_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [wma_pkg::CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

### hw/rtl/wma_ram.sv
`default_nettype none

module wma_ram #(
    parameter int WIDTH = wma_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = wma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

### hw/rtl/wma_div.sv
`default_nettype none

module wma_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W:0]   r_rem;
    logic [DVS_W:0]   n_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVD_W-1:0] n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   shifted;
    logic             fits;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        shifted = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
        n_rem   = fits ? (shifted - {1'b0, r_dvs}) : shifted;
        n_quo   = {r_quo[DVD_W-2:0], fits};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

`default_nettype wire

### hw/rtl/windowed_moving_average_unit.sv
`default_nettype none

// Boxcar moving average over the last window_size signed samples. Each sample request
// lands in a ring buffer RAM and updates an exact running sum; once the window is full
// the oldest sample is read back and subtracted. The result is sum * 256 / samples held,
// truncated toward zero and saturated to 24 bits, plus the held count. A clear request
// empties the filter and answers zero; a window_size write (0 reads as 1, values above
// MAX_WINDOW clamp) also empties it and is taken only while the unit is idle. A sample
// request passes through a serial divider that produces one quotient bit per cycle, and
// no new request is taken until its result is loaded into the output register. The result
// sits in an output register, so the next request is taken while it waits. No clearing
// pass follows reset.
module windowed_moving_average_unit #(
    parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wma_cfg_if.sink    i_cfg,
    wma_in_if.sink     i_smp,
    wma_out_if.source  o_res
);
    localparam int COUNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DVD_W     = SUM_W + wma_pkg::FRAC_W;
    localparam int EXT_W     = (DVD_W > wma_pkg::AVG_W + 1) ? DVD_W : wma_pkg::AVG_W + 1;
    localparam int CMP_W     = (wma_pkg::CFG_W > COUNT_W) ? wma_pkg::CFG_W : COUNT_W;
    localparam int WIN_RESET = (MAX_WINDOW < wma_pkg::WIN_RESET_DEF) ?
                               MAX_WINDOW : wma_pkg::WIN_RESET_DEF;

    wma_pkg::t_state r_state;
    wma_pkg::t_state n_state;

    logic [COUNT_W-1:0]            r_win;
    logic [PTR_W-1:0]              r_wptr;
    logic [COUNT_W-1:0]            r_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic [SAMPLE_BITS-1:0]        r_sample;
    logic                          r_clr;
    logic                          r_neg;
    logic                          r_out_valid;
    logic [wma_pkg::AVG_W-1:0]     r_avg;
    logic [COUNT_W-1:0]            r_held;

    logic                          smp_ready;
    logic                          cfg_ready;
    logic                          smp_acc;
    logic                          cfg_acc;
    logic                          mem_we;
    logic                          div_start;
    logic                          out_load;
    logic                          full;
    logic [PTR_W-1:0]              n_wptr;
    logic [CMP_W-1:0]              cfg_ext;
    logic [COUNT_W-1:0]            win_sat;
    logic [SAMPLE_BITS-1:0]        mem_rdata;
    logic [SUM_W-1:0]              sum_mag;
    logic [DVD_W-1:0]              dividend;
    logic                          div_done;
    logic [DVD_W-1:0]              div_quo;
    logic [EXT_W-1:0]              q_ext;
    logic [wma_pkg::AVG_W-1:0]     avg_val;

    assign smp_acc = i_smp.valid && smp_ready;
    assign cfg_acc = i_cfg.valid && cfg_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wma_pkg::S_IDLE: begin
                if (smp_acc) begin
                    n_state = (i_smp.kind == wma_pkg::KIND_CLEAR) ?
                              wma_pkg::S_DONE : wma_pkg::S_UPDATE;
                end
            end
            wma_pkg::S_UPDATE:    n_state = wma_pkg::S_DIV_START;
            wma_pkg::S_DIV_START: n_state = wma_pkg::S_DIV_WAIT;
            wma_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = wma_pkg::S_DONE;
                end
            end
            wma_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = wma_pkg::S_IDLE;
                end
            end
            default: n_state = wma_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        smp_ready = 1'b0;
        cfg_ready = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            wma_pkg::S_IDLE: begin
                cfg_ready = 1'b1;
                smp_ready = !i_cfg.valid;
            end
            wma_pkg::S_UPDATE:    mem_we    = 1'b1;
            wma_pkg::S_DIV_START: div_start = 1'b1;
            wma_pkg::S_DIV_WAIT:  out_load  = 1'b0;
            wma_pkg::S_DONE:      out_load  = !r_out_valid || o_res.ready;
            default:              out_load  = 1'b0;
        endcase
    end

    // window write, clamped into 1..MAX_WINDOW
    always_comb begin
        cfg_ext = CMP_W'(i_cfg.window_size);
        if (cfg_ext == '0) begin
            win_sat = COUNT_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
            win_sat = COUNT_W'(MAX_WINDOW);
        end else begin
            win_sat = COUNT_W'(cfg_ext);
        end
    end

    // running sum update with the oldest sample leaving a full window
    always_comb begin
        full  = (r_count >= r_win);
        n_sum = r_sum + SUM_W'(signed'(r_sample));
        if (full) begin
            n_sum = n_sum - SUM_W'(signed'(mem_rdata));
        end
        if ((COUNT_W'(r_wptr) + COUNT_W'(1)) == r_win) begin
            n_wptr = '0;
        end else begin
            n_wptr = r_wptr + PTR_W'(1);
        end
    end

    // sample ring buffer
    wma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_wma_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_re    (smp_acc),
        .i_raddr (r_wptr),
        .o_rdata (mem_rdata)
    );

    // magnitude of the sum, scaled by the fraction bits
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign dividend = {sum_mag, {wma_pkg::FRAC_W{1'b0}}};

    // serial divider
    wma_div #(
        .DVD_W (DVD_W),
        .DVS_W (COUNT_W)
    ) u_wma_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sign restore and saturation
    always_comb begin
        q_ext = EXT_W'(div_quo);
        if (r_clr) begin
            avg_val = '0;
        end else if (!r_neg && (q_ext > EXT_W'(wma_pkg::AVG_POS_LIM))) begin
            avg_val = wma_pkg::AVG_MAX;
        end else if (r_neg && (q_ext > EXT_W'(wma_pkg::AVG_NEG_LIM))) begin
            avg_val = wma_pkg::AVG_MIN;
        end else if (r_neg) begin
            avg_val = -q_ext[wma_pkg::AVG_W-1:0];
        end else begin
            avg_val = q_ext[wma_pkg::AVG_W-1:0];
        end
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wma_pkg::S_IDLE;
            r_win       <= COUNT_W'(WIN_RESET);
            r_wptr      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_win   <= win_sat;
                r_wptr  <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end else if (smp_acc && (i_smp.kind == wma_pkg::KIND_CLEAR)) begin
                r_wptr  <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end else if (mem_we) begin
                r_wptr <= n_wptr;
                r_sum  <= n_sum;
                if (!full) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_sample <= i_smp.sample;
            r_clr    <= (i_smp.kind == wma_pkg::KIND_CLEAR);
        end
        if (div_start) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (out_load) begin
            r_avg  <= avg_val;
            r_held <= r_count;
        end
    end

    assign i_smp.ready      = smp_ready;
    assign i_cfg.ready      = cfg_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.average_q8 = r_avg;
    assign o_res.held_count = r_held;
endmodule

`default_nettype wire

### hw/rtl/wma_checker.sv
`default_nettype none

`include "windowed_moving_average_unit_macros.svh"

module wma_checker #(
    parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW_DEF,
    parameter int COUNT_W    = $clog2(wma_pkg::MAX_WINDOW_DEF + 1)
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_smp_valid,
    input wire logic                      i_smp_ready,
    input wire logic                      i_res_valid,
    input wire logic                      i_res_ready,
    input wire logic [wma_pkg::AVG_W-1:0] i_avg,
    input wire logic [COUNT_W-1:0]        i_held
);
    // held count never exceeds the largest window
    `WMA_ASSERT_IMP(a_held_max, i_clk, i_rst_n, i_res_valid, i_held <= COUNT_W'(MAX_WINDOW), "held count beyond window")

    // an empty filter always answers zero
    `WMA_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_res_valid && (i_held == '0), i_avg == '0, "nonzero average with nothing held")

    // one request in work at a time
    `WMA_ASSERT_NXT(a_one_in_work, i_clk, i_rst_n, i_smp_valid && i_smp_ready, !i_smp_ready, "request taken while busy")

    // a stalled result holds
    `WMA_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_avg) && $stable(i_held), "stalled result changed")
endmodule

bind windowed_moving_average_unit wma_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .COUNT_W    (COUNT_W)
) u_wma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_smp_valid (i_smp.valid),
    .i_smp_ready (i_smp.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_avg       (o_res.average_q8),
    .i_held      (o_res.held_count)
);

`default_nettype wire
